// File: hdl/lr4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lr4_pkg;

   localparam int NUM_CHANNELS_DEF = 8;

   // payload and register widths
   localparam int CH_W       = 3;
   localparam int SMP_W      = 24;
   localparam int COEF_W     = 32;
   localparam int GAIN_W     = 24;
   localparam int MIX_W      = 17;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // arithmetic widths
   localparam int SIG_W  = 48;             // filter signal and delay states
   localparam int FRAC_W = 16;             // signal units below one sample LSB
   localparam int HALF_W = SIG_W / 2;      // multiplier operand split
   localparam int C_W    = COEF_W + 1;     // multiplier second operand, signed
   localparam int PL_W   = HALF_W + 1 + C_W;
   localparam int PH_W   = HALF_W + C_W;
   localparam int FULL_W = SIG_W + C_W + 1;
   localparam int MR_W   = 54;             // rounded product
   localparam int ACC_W  = 56;             // sums of rounded products
   localparam int O_W    = ACC_W - FRAC_W;

   localparam logic [MIX_W-1:0]  MIX_ONE        = 17'h10000;
   localparam logic [GAIN_W-1:0] GAIN_RESET     = 24'h100000;

   // register map
   localparam logic [REG_IDX_W-1:0] REG_COEF_B0  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_B1  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_B2  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF_A1  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_A2  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_WET_GAIN = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_WET_MIX  = 3'd6;

   // sequencer
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_type;

   typedef enum logic [1:0] {A_XS, A_Y, A_W, A_XD} a_sel_type;

   typedef enum logic [2:0] {
      C_B0, C_B1, C_B2, C_A1, C_A2, C_GAIN, C_DRY, C_WET
   } c_sel_type;

   typedef enum logic [1:0] {SH_30, SH_20, SH_16, SH_0} sh_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_Y, ACT_T1, ACT_T2, ACT_ND1, ACT_ND2, ACT_W, ACT_M0, ACT_M1
   } act_type;

   typedef struct packed {
      a_sel_type a_sel;
      c_sel_type c_sel;
      sh_type    sh;
      act_type   act;
      logic      bank;
   } mop_type;

   typedef struct packed {
      logic    load;
      logic    finish;
      mop_type mop;
   } cmd_type;

   typedef struct packed {
      logic in_range;
   } sts_type;

   // clamp a wide sum to the signal range
   function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-SIG_W:0] top;
      top = v[ACC_W-1:SIG_W-1];
      if (top == '0 || top == '1) begin
         return v[SIG_W-1:0];
      end
      if (v[ACC_W-1]) begin
         return {1'b1, {(SIG_W-1){1'b0}}};
      end
      return {1'b0, {(SIG_W-1){1'b1}}};
   endfunction

   // multiply schedule: each op's result passes the product and rounding registers
   function automatic mop_type step_cmd(input logic [STEP_W-1:0] step);
      mop_type m;
      m = '{a_sel: A_XS, c_sel: C_B0, sh: SH_30, act: ACT_NONE, bank: 1'b0};
      unique case (step)
         4'd0:  m = '{a_sel: A_XS, c_sel: C_B0, sh: SH_30, act: ACT_Y,   bank: 1'b0};
         4'd1:  m = '{a_sel: A_XS, c_sel: C_B1, sh: SH_30, act: ACT_T1,  bank: 1'b0};
         4'd2:  m = '{a_sel: A_XS, c_sel: C_B2, sh: SH_30, act: ACT_T2,  bank: 1'b0};
         4'd3:  m = '{a_sel: A_Y,  c_sel: C_A1, sh: SH_30, act: ACT_ND1, bank: 1'b0};
         4'd4:  m = '{a_sel: A_Y,  c_sel: C_A2, sh: SH_30, act: ACT_ND2, bank: 1'b0};
         4'd5:  m = '{a_sel: A_XS, c_sel: C_B0, sh: SH_30, act: ACT_Y,   bank: 1'b1};
         4'd6:  m = '{a_sel: A_XS, c_sel: C_B1, sh: SH_30, act: ACT_T1,  bank: 1'b1};
         4'd7:  m = '{a_sel: A_XS, c_sel: C_B2, sh: SH_30, act: ACT_T2,  bank: 1'b1};
         4'd8:  m = '{a_sel: A_Y,  c_sel: C_A1, sh: SH_30, act: ACT_ND1, bank: 1'b1};
         4'd9:  m = '{a_sel: A_Y,  c_sel: C_A2, sh: SH_30, act: ACT_ND2, bank: 1'b1};
         4'd10: m = '{a_sel: A_Y,  c_sel: C_GAIN, sh: SH_20, act: ACT_W,  bank: 1'b0};
         4'd11: m = '{a_sel: A_XD, c_sel: C_DRY,  sh: SH_0,  act: ACT_M0, bank: 1'b0};
         4'd13: m = '{a_sel: A_W,  c_sel: C_WET,  sh: SH_16, act: ACT_M1, bank: 1'b0};
         default: m.act = ACT_NONE;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: hdl/lr4_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lr4_req_if;
   import lr4_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CH_W-1:0]         channel;
   logic signed [SMP_W-1:0] sample_in;

   modport source (output valid, channel, sample_in, input ready);
   modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface lr4_rsp_if;
   import lr4_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CH_W-1:0]         channel_out;
   logic signed [SMP_W-1:0] sample_out;
   logic                    clipped;

   modport source (output valid, channel_out, sample_out, clipped, input ready);
   modport sink   (input valid, channel_out, sample_out, clipped, output ready);
endinterface

`default_nettype wire

// File: hdl/lr4_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module lr4_dpath #(
   parameter int NUM_CHANNELS = lr4_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [lr4_pkg::REG_IDX_W-1:0]          csr_index,
   input  logic [lr4_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic [lr4_pkg::CH_W-1:0]               in_channel,
   input  logic signed [lr4_pkg::SMP_W-1:0]       in_sample,
   input  lr4_pkg::cmd_type                       cmd,
   output lr4_pkg::sts_type                       sts,
   output logic [lr4_pkg::CH_W-1:0]               out_channel,
   output logic signed [lr4_pkg::SMP_W-1:0]       out_sample,
   output logic                                   out_clipped
);
   import lr4_pkg::*;

   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // configuration
   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic [MIX_W-1:0]         mix_ff;
   logic [MIX_W-1:0]         wet, dry;

   // item registers
   logic [CH_W-1:0]          ch_ff;
   logic signed [SMP_W-1:0]  smp_ff;
   logic                     in_range_ff;
   logic [ADDR_W-1:0]        idx;

   // per-channel biquad states, bank 0 is the first pass
   logic signed [SIG_W-1:0]  dly1_ff [2][NUM_CHANNELS];
   logic signed [SIG_W-1:0]  dly2_ff [2][NUM_CHANNELS];
   logic signed [SIG_W-1:0]  d1_rd, d2_rd;

   // working registers
   logic signed [SIG_W-1:0]  xs_ff, y_ff, w_ff;
   logic signed [ACC_W-1:0]  t1_ff, t2_ff, macc_ff;

   // multiplier pipeline
   logic signed [SIG_W-1:0]  opa;
   logic signed [C_W-1:0]    opc;
   logic signed [PL_W-1:0]   pl_ff;
   logic signed [PH_W-1:0]   ph_ff;
   act_type                  m_act_ff, r_act_ff;
   logic                     m_bank_ff, r_bank_ff;
   sh_type                   m_sh_ff;
   logic signed [FULL_W-1:0] full;
   logic signed [MR_W-1:0]   mr_in, mr_ff;

   // accumulate stage
   logic signed [ACC_W-1:0]  acc_a, y_sum, t1_sum, nd1_sum, nd2_sum, m1_sum;

   // output
   logic signed [ACC_W-1:0]  o_sum;
   logic signed [O_W-1:0]    o_full;
   logic                     o_clip;
   logic signed [SMP_W-1:0]  o_sat;
   logic [CH_W-1:0]          out_channel_ff;
   logic signed [SMP_W-1:0]  out_sample_ff;
   logic                     out_clipped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff   <= '0;
         b1_ff   <= '0;
         b2_ff   <= '0;
         a1_ff   <= '0;
         a2_ff   <= '0;
         gain_ff <= GAIN_RESET;
         mix_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_COEF_B0:  b0_ff   <= csr_wdata[COEF_W-1:0];
            REG_COEF_B1:  b1_ff   <= csr_wdata[COEF_W-1:0];
            REG_COEF_B2:  b2_ff   <= csr_wdata[COEF_W-1:0];
            REG_COEF_A1:  a1_ff   <= csr_wdata[COEF_W-1:0];
            REG_COEF_A2:  a2_ff   <= csr_wdata[COEF_W-1:0];
            REG_WET_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_WET_MIX:  mix_ff  <= csr_wdata[MIX_W-1:0];
            default: ;
         endcase
      end
   end

   assign wet = (mix_ff > MIX_ONE) ? MIX_ONE : mix_ff;
   assign dry = MIX_ONE - wet;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff       <= in_channel;
         smp_ff      <= in_sample;
         in_range_ff <= (32'(in_channel) < NUM_CHANNELS);
      end
   end

   assign sts.in_range = in_range_ff;
   assign idx = ADDR_W'(ch_ff);

   // operand select and split multiply
   always_comb begin
      unique case (cmd.mop.a_sel)
         A_XS:    opa = xs_ff;
         A_Y:     opa = y_ff;
         A_W:     opa = w_ff;
         A_XD:    opa = SIG_W'(smp_ff);
         default: opa = xs_ff;
      endcase
      unique case (cmd.mop.c_sel)
         C_B0:    opc = C_W'(b0_ff);
         C_B1:    opc = C_W'(b1_ff);
         C_B2:    opc = C_W'(b2_ff);
         C_A1:    opc = C_W'(a1_ff);
         C_A2:    opc = C_W'(a2_ff);
         C_GAIN:  opc = $signed(C_W'(gain_ff));
         C_DRY:   opc = $signed(C_W'(dry));
         C_WET:   opc = $signed(C_W'(wet));
         default: opc = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      pl_ff   <= $signed({1'b0, opa[HALF_W-1:0]}) * opc;
      ph_ff   <= $signed(opa[SIG_W-1:HALF_W]) * opc;
      m_sh_ff <= cmd.mop.sh;
      m_bank_ff <= cmd.mop.bank;
      r_bank_ff <= m_bank_ff;
      mr_ff   <= mr_in;
      if (reset) begin
         m_act_ff <= ACT_NONE;
         r_act_ff <= ACT_NONE;
      end else begin
         m_act_ff <= cmd.mop.act;
         r_act_ff <= m_act_ff;
      end
   end

   // recombine halves, round half up, drop fraction bits
   always_comb begin
      full = (FULL_W'(ph_ff) <<< HALF_W) + FULL_W'(pl_ff);
      unique case (m_sh_ff)
         SH_30:   mr_in = MR_W'((full + (FULL_W'(1) <<< 29)) >>> 30);
         SH_20:   mr_in = MR_W'((full + (FULL_W'(1) <<< 19)) >>> 20);
         SH_16:   mr_in = MR_W'((full + (FULL_W'(1) <<< 15)) >>> 16);
         SH_0:    mr_in = MR_W'(full);
         default: mr_in = MR_W'(full);
      endcase
   end

   always_comb begin
      d1_rd   = dly1_ff[r_bank_ff][idx];
      d2_rd   = dly2_ff[r_bank_ff][idx];
      acc_a   = ACC_W'(mr_ff);
      y_sum   = ACC_W'(d1_rd) + acc_a;
      t1_sum  = acc_a + ACC_W'(d2_rd);
      nd1_sum = t1_ff - acc_a;
      nd2_sum = t2_ff - acc_a;
      m1_sum  = macc_ff + acc_a;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xs_ff <= SIG_W'($signed({in_sample, {FRAC_W{1'b0}}}));
      end
      case (r_act_ff)
         ACT_Y: begin
            y_ff  <= sat_sig(y_sum);
            xs_ff <= sat_sig(y_sum);    // next pass input
         end
         ACT_T1: t1_ff   <= t1_sum;
         ACT_T2: t2_ff   <= acc_a;
         ACT_W:  w_ff    <= sat_sig(acc_a);
         ACT_M0: macc_ff <= acc_a;
         ACT_M1: macc_ff <= m1_sum;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               dly1_ff[b][i] <= '0;
               dly2_ff[b][i] <= '0;
            end
         end
      end else begin
         if (r_act_ff == ACT_ND1) begin
            dly1_ff[r_bank_ff][idx] <= sat_sig(nd1_sum);
         end
         if (r_act_ff == ACT_ND2) begin
            dly2_ff[r_bank_ff][idx] <= sat_sig(nd2_sum);
         end
      end
   end

   // final rounding and clamp to 24 bits
   always_comb begin
      o_sum  = macc_ff + ACC_W'(1 << (FRAC_W - 1));
      o_full = o_sum[ACC_W-1:FRAC_W];
      o_clip = !(o_full[O_W-1:SMP_W-1] == '0 || o_full[O_W-1:SMP_W-1] == '1);
      if (!o_clip) begin
         o_sat = o_full[SMP_W-1:0];
      end else if (o_full[O_W-1]) begin
         o_sat = {1'b1, {(SMP_W-1){1'b0}}};
      end else begin
         o_sat = {1'b0, {(SMP_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_channel_ff <= ch_ff;
         out_sample_ff  <= in_range_ff ? o_sat : smp_ff;
         out_clipped_ff <= in_range_ff & o_clip;
      end
   end

   assign out_channel = out_channel_ff;
   assign out_sample  = out_sample_ff;
   assign out_clipped = out_clipped_ff;

endmodule

`default_nettype wire

// File: hdl/lr4_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lr4_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  lr4_pkg::sts_type sts,
   output lr4_pkg::cmd_type cmd
);
   import lr4_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              full_ff, full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         full_ff  <= full_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!sts.in_range) begin
               state_in = ST_FINISH;      // unknown channel: pass the sample through
            end else begin
               cmd.mop = step_cmd(step_ff);
               if (step_ff == LAST_STEP) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!full_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         full_in = 1'b1;
      end else if (rsp_ready) begin
         full_in = 1'b0;
      end else begin
         full_in = full_ff;
      end
   end

   assign rsp_valid = full_ff;

   a_run_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && $past(state_ff) == ST_IDLE) |-> step_ff == '0)
      else $error("sequence did not start at step zero");

   a_full_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(full_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result register filled outside finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && full_ff && !rsp_ready) |=> state_ff == ST_FINISH)
      else $error("pending result overwritten");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff == LAST_STEP) |=> state_ff == ST_FINISH)
      else $error("sequence overran its last step");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_RUN)
      else $error("accepted sample not processed");

endmodule

`default_nettype wire

// File: hdl/lr4_lowpass_tdm_filter.sv
// Fourth-order Linkwitz-Riley lowpass for time-multiplexed audio channels.
// req_chan carries one sample and its channel number; rsp_chan returns the
// filtered, gained and wet/dry mixed sample, clamped to 24 bits with a clip
// flag, for the same channel. Both channels use valid/ready; one transfer
// on req_chan gives exactly one transfer on rsp_chan, in order.
// Coefficients, gain and mix are written through csr_*, by the user only
// while idle, which the block does not enforce; unused indices are dropped.
// One shared 24x33 split multiplier (two partial products, then a rounding
// stage) does all 13 products; the per-item sequence is 16 steps, and a new
// sample is taken only once the previous result has moved to the output
// register. A sample for a channel number of NUM_CHANNELS or more is passed
// through without touching any filter state.
// Reset clears all filter states and loads the default registers (unity
// gain, dry only). The result sits in an output register: a stalled rsp
// side still lets the next sample in and be computed, and only the final
// handoff waits for the register to empty.
`timescale 1ns / 1ps
`default_nettype none

module lr4_lowpass_tdm_filter #(
   parameter int NUM_CHANNELS = lr4_pkg::NUM_CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   lr4_req_if.sink                        req_chan,
   lr4_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [lr4_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [lr4_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lr4_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lr4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lr4_dpath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_channel   (req_chan.channel),
      .in_sample    (req_chan.sample_in),
      .cmd          (cmd),
      .sts          (sts),
      .out_channel  (rsp_chan.channel_out),
      .out_sample   (rsp_chan.sample_out),
      .out_clipped  (rsp_chan.clipped)
   );

endmodule

`default_nettype wire
